FILE: design/jet_pkg.sv
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types, constants and helpers for the Julia escape-time pixel block.
// ----------------------------------------------------------------------------
package jet_pkg;

  // Default geometry and iteration limit
  localparam int DEF_WIDTH          = 1024;
  localparam int DEF_HEIGHT         = 1024;
  localparam int DEF_MAX_ITERATIONS = 256;

  // Pixel and result field widths
  localparam int PIX_W   = 10;
  localparam int LEVEL_W = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Color level moduli
  localparam logic [LEVEL_W-1:0] RED_MOD = 9'd300;
  localparam logic [LEVEL_W-1:0] GB_MOD  = 9'd270;

  // Q4.28 arithmetic
  localparam int FRAC_BITS = 28;
  // 4.0 in Q8.56
  localparam logic [63:0] ESC_LIMIT = 64'h0400_0000_0000_0000;
  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] SAT_MIN = 64'shffff_ffff_8000_0000;

  // Register reset values
  localparam logic [30:0] STEP_RE_RST = 31'd786432;
  localparam logic [30:0] STEP_IM_RST = 31'd524288;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONST_RE  = 3'd0,
    REG_CONST_IM  = 3'd1,
    REG_OFFSET_RE = 3'd2,
    REG_OFFSET_IM = 3'd3,
    REG_STEP_RE   = 3'd4,
    REG_STEP_IM   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0]   out_x;
    logic [PIX_W-1:0]   out_y;
    logic [LEVEL_W-1:0] iterations;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_blue_level;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic load_pix;
    logic scale;
    logic start;
    logic mul;
    logic upd;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic escaped;
    logic at_limit;
  } dp_stat_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

FILE: design/julia_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel
// Escape-time evaluation of one pixel of a Julia set in Q4.28 fixed point.
//
//   channel  ports                          word
//   in       in_valid, in_stall, in_data    pixel_x, pixel_y
//   out      out_valid, out_stall, out_data out_x, out_y, iterations, levels
//   cfg      cfg_we, cfg_index, cfg_wdata   six registers, write only
//
// Each iteration has two steps: the MUL state registers the three 32x32
// products, and the UPD state does the escape test and the z update. One pixel
// is in flight at a time; the next is accepted while a finished word waits in
// the output register. Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel #(
  parameter int WIDTH          = jet_pkg::DEF_WIDTH,
  parameter int HEIGHT         = jet_pkg::DEF_HEIGHT,
  parameter int MAX_ITERATIONS = jet_pkg::DEF_MAX_ITERATIONS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  jet_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output jet_pkg::out_word_t             out_data,
  input  logic                           cfg_we,
  input  logic [jet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jet_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  jet_pkg::dp_cmd_t  cmd;
  jet_pkg::dp_stat_t stat;

  jet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  jet_dpath #(
    .WIDTH          (WIDTH),
    .HEIGHT         (HEIGHT),
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: design/jet_ctrl.sv
// ----------------------------------------------------------------------------
// jet_ctrl
// Sequencer: accepts a pixel, steps the datapath through scaling, start point
// and the multiply/update loop, and hands the result to the output register.
// ----------------------------------------------------------------------------
module jet_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  jet_pkg::dp_stat_t  stat,
  output jet_pkg::dp_cmd_t   cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCALE = 6'b000010,
    ST_START = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_HOLD  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_pix = 1'b1;
          state_nxt    = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_START;
      end
      ST_START: begin
        cmd.start = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (!stat.escaped && !stat.at_limit) begin
          cmd.upd   = 1'b1;
          state_nxt = ST_MUL;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // wait for the output register to drain
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/jet_dpath.sv
// ----------------------------------------------------------------------------
// jet_dpath
// Datapath: configuration registers, start point scaling, the z*z + c
// multiply/update loop, iteration and color level counters, output register.
// ----------------------------------------------------------------------------
module jet_dpath #(
  parameter int WIDTH          = jet_pkg::DEF_WIDTH,
  parameter int HEIGHT         = jet_pkg::DEF_HEIGHT,
  parameter int MAX_ITERATIONS = jet_pkg::DEF_MAX_ITERATIONS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [jet_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jet_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  jet_pkg::in_word_t                  in_data,
  output jet_pkg::out_word_t                 out_data,
  input  jet_pkg::dp_cmd_t                   cmd,
  output jet_pkg::dp_stat_t                  stat
);

  localparam int HALF_X = WIDTH / 2;
  localparam int HALF_Y = HEIGHT / 2;
  localparam int HX_W   = $clog2(HALF_X + 1);
  localparam int HY_W   = $clog2(HALF_Y + 1);
  localparam int DX_W   = ((HX_W > jet_pkg::PIX_W) ? HX_W : jet_pkg::PIX_W) + 1;
  localparam int DY_W   = ((HY_W > jet_pkg::PIX_W) ? HY_W : jet_pkg::PIX_W) + 1;
  localparam int CNT_W  = $clog2(MAX_ITERATIONS + 1);
  localparam int LW     = jet_pkg::LEVEL_W;

  // Configuration registers
  logic signed [31:0] const_re_r, const_im_r, off_re_r, off_im_r;
  logic [30:0]        step_re_r, step_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_re_r <= '0;
      const_im_r <= '0;
      off_re_r   <= '0;
      off_im_r   <= '0;
      step_re_r  <= jet_pkg::STEP_RE_RST;
      step_im_r  <= jet_pkg::STEP_IM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jet_pkg::REG_CONST_RE:  const_re_r <= $signed(cfg_wdata);
        jet_pkg::REG_CONST_IM:  const_im_r <= $signed(cfg_wdata);
        jet_pkg::REG_OFFSET_RE: off_re_r   <= $signed(cfg_wdata);
        jet_pkg::REG_OFFSET_IM: off_im_r   <= $signed(cfg_wdata);
        jet_pkg::REG_STEP_RE:   step_re_r  <= cfg_wdata[30:0];
        jet_pkg::REG_STEP_IM:   step_im_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Held pixel
  logic [jet_pkg::PIX_W-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      px_r <= in_data.pixel_x;
      py_r <= in_data.pixel_y;
    end
  end

  // Start point scaling: (pix - half) * step
  logic signed [DX_W-1:0]    dx;
  logic signed [DY_W-1:0]    dy;
  logic signed [DX_W+31:0]   prod_x_nxt, prod_x_r;
  logic signed [DY_W+31:0]   prod_y_nxt, prod_y_r;

  assign dx = $signed(DX_W'(px_r)) - $signed(DX_W'(HALF_X));
  assign dy = $signed(DY_W'(py_r)) - $signed(DY_W'(HALF_Y));
  assign prod_x_nxt = dx * $signed({1'b0, step_re_r});
  assign prod_y_nxt = dy * $signed({1'b0, step_im_r});

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
    end
  end

  // Start coordinates: saturate the product, add offset, saturate again
  logic signed [63:0] sx_sum, sy_sum;
  logic signed [31:0] start_re, start_im;

  always_comb begin
    sx_sum   = 64'(jet_pkg::sat32(64'(prod_x_r))) + 64'(off_re_r);
    sy_sum   = 64'(jet_pkg::sat32(64'(prod_y_r))) + 64'(off_im_r);
    start_re = jet_pkg::sat32(sx_sum);
    start_im = jet_pkg::sat32(sy_sum);
  end

  // Iteration: products are registered, escape test and update follow in the next cycle
  logic signed [31:0] z_re_r, z_im_r;
  logic signed [63:0] rr_r, ii_r, ri_r;
  logic signed [63:0] rr_nxt, ii_nxt, ri_nxt;
  logic signed [63:0] nre, nim;
  logic [63:0]        mag;

  assign rr_nxt = z_re_r * z_re_r;
  assign ii_nxt = z_im_r * z_im_r;
  assign ri_nxt = z_re_r * z_im_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rr_r <= rr_nxt;
      ii_r <= ii_nxt;
      ri_r <= ri_nxt;
    end
  end

  always_comb begin
    // squares are non-negative, so the sum fits 64 bits unsigned
    mag = $unsigned(rr_r) + $unsigned(ii_r);
    nre = ((rr_r - ii_r) >>> jet_pkg::FRAC_BITS) + 64'(const_re_r);
    nim = (ri_r >>> (jet_pkg::FRAC_BITS - 1)) + 64'(const_im_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      z_re_r <= start_re;
      z_im_r <= start_im;
    end else if (cmd.upd) begin
      z_re_r <= jet_pkg::sat32(nre);
      z_im_r <= jet_pkg::sat32(nim);
    end
  end

  // Iteration count and running color levels
  logic [CNT_W-1:0]  count_r;
  logic [LW-1:0]     red_r, gb_r;
  logic [CNT_W+LW-1:0] cnt_ext;

  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      count_r <= '0;
      red_r   <= '0;
      gb_r    <= '0;
    end else if (cmd.upd) begin
      count_r <= count_r + 1'b1;
      red_r   <= (red_r == jet_pkg::RED_MOD - 1'b1) ? '0 : red_r + 1'b1;
      gb_r    <= (gb_r == jet_pkg::GB_MOD - 1'b1) ? '0 : gb_r + 1'b1;
    end
  end

  assign cnt_ext       = {{LW{1'b0}}, count_r};
  assign stat.at_limit = (count_r == CNT_W'(MAX_ITERATIONS));
  assign stat.escaped  = (mag > jet_pkg::ESC_LIMIT);

  // Output register
  jet_pkg::out_word_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.out_x            <= px_r;
      out_r.out_y            <= py_r;
      out_r.iterations       <= cnt_ext[LW-1:0];
      out_r.red_level        <= red_r;
      out_r.green_blue_level <= gb_r;
    end
  end

  assign out_data = out_r;

endmodule

FILE: dv/julia_escape_time_pixel_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_tb
// Self-checking bench for the Julia escape-time pixel block. Pixels go in
// over the valid/stall channel. A local fixed-point model predicts each
// result word from the shadowed view registers, and every word that comes
// out is compared with the oldest prediction. Directed pixels cover the
// reset view, the escape radius edge, saturation and ignored register
// indexes. Randomized views and pixels follow, with random gaps on both
// sides, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_tb;
  import jet_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int IDLE_PCT       = 28;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  julia_escape_time_pixel u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the view registers, reset values
  logic signed [31:0] view_c_re    = '0;
  logic signed [31:0] view_c_im    = '0;
  logic signed [31:0] view_off_re  = '0;
  logic signed [31:0] view_off_im  = '0;
  logic [30:0]        view_step_re = STEP_RE_RST;
  logic [30:0]        view_step_im = STEP_IM_RST;

  out_word_t pixel_results_due[$];

  bit idle_on = 1'b1;
  int hold_requests;
  int hold_served;
  int hold_left;
  int quiet_cycles;
  int pixels_sent;
  int views_loaded;
  int results_checked;
  int mismatch_count;
  int limit_hits;
  int instant_escapes;
  logic      stalled_word_pending;
  out_word_t stalled_word;

  // ---------------------------------------------------------------- model
  function automatic logic signed [31:0] clamp_q428(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] start_point(input logic [PIX_W-1:0] pix,
                                                     input int half,
                                                     input logic [30:0] step,
                                                     input logic signed [31:0] off);
    logic signed [63:0] pix_delta;
    logic signed [63:0] base;
    pix_delta = $signed({54'd0, pix}) - half;
    base = clamp_q428(pix_delta * $signed({33'd0, step}));
    return clamp_q428(base + off);
  endfunction

  function automatic out_word_t escape_pixel(input in_word_t px);
    logic signed [63:0] re, im, rr, ii, ri;
    int unsigned count;
    out_word_t w;
    re = start_point(px.pixel_x, DEF_WIDTH / 2, view_step_re, view_off_re);
    im = start_point(px.pixel_y, DEF_HEIGHT / 2, view_step_im, view_off_im);
    rr = re * re;
    ii = im * im;
    count = 0;
    // |z|^2 is exact in Q8.56; the sum may reach 2^63, so compare unsigned
    while (count < DEF_MAX_ITERATIONS && rr + ii <= ESC_LIMIT) begin
      ri = re * im;
      re = clamp_q428(((rr - ii) >>> FRAC_BITS) + view_c_re);
      im = clamp_q428((ri >>> (FRAC_BITS - 1)) + view_c_im);
      rr = re * re;
      ii = im * im;
      count++;
    end
    w.out_x            = px.pixel_x;
    w.out_y            = px.pixel_y;
    w.iterations       = count[LEVEL_W-1:0];
    w.red_level        = LEVEL_W'(count % RED_MOD);
    w.green_blue_level = LEVEL_W'(count % GB_MOD);
    return w;
  endfunction

  // --------------------------------------------------------------- helpers
  function automatic logic [31:0] q428(input real v);
    return $rtoi(v * 268435456.0);
  endfunction

  function automatic logic [31:0] rand_around(input int unsigned half_span);
    return $urandom_range(0, 2 * half_span) - half_span;
  endfunction

  function automatic in_word_t rand_pixel();
    in_word_t p;
    p.pixel_x = $urandom_range(0, 1023);
    p.pixel_y = $urandom_range(0, 1023);
    return p;
  endfunction

  // Leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_CONST_RE:  view_c_re    = val;
      REG_CONST_IM:  view_c_im    = val;
      REG_OFFSET_RE: view_off_re  = val;
      REG_OFFSET_IM: view_off_im  = val;
      REG_STEP_RE:   view_step_re = val[30:0];
      REG_STEP_IM:   view_step_im = val[30:0];
      default: ;
    endcase
  endtask

  task automatic load_view(input logic [31:0] c_re, c_im, off_re, off_im, stp_re, stp_im);
    write_reg(REG_CONST_RE, c_re);
    write_reg(REG_CONST_IM, c_im);
    write_reg(REG_OFFSET_RE, off_re);
    write_reg(REG_OFFSET_IM, off_im);
    write_reg(REG_STEP_RE, stp_re);
    write_reg(REG_STEP_IM, stp_im);
    cfg_we <= 1'b0;
    @(posedge clk);
    views_loaded++;
  endtask

  // Leaves in_valid high so back-to-back pixels need no dead cycle
  task automatic send_pixel(input in_word_t px);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixel_results_due.push_back(escape_pixel(px));
    pixels_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input out_word_t want, input out_word_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: exp x=%0d y=%0d it=%0d r=%0d gb=%0d got x=%0d y=%0d it=%0d r=%0d gb=%0d",
               $time, what, want.out_x, want.out_y, want.iterations, want.red_level,
               want.green_blue_level, got.out_x, got.out_y, got.iterations, got.red_level,
               got.green_blue_level);
  endtask

  // --------------------------------------------------------------- checker
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && stalled_word_pending && (out_valid !== 1'b1 || out_data !== stalled_word))
      note_mismatch("word changed while stalled", stalled_word, out_data);
    stalled_word_pending = rst_n && out_valid === 1'b1 && out_stall;
    stalled_word = out_data;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pixel_results_due.size() == 0) begin
        note_mismatch("unexpected word", '0, out_data);
      end else begin
        want = pixel_results_due.pop_front();
        results_checked++;
        if (want.iterations == LEVEL_W'(DEF_MAX_ITERATIONS)) limit_hits++;
        if (want.iterations == '0) instant_escapes++;
        if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
            out_data.iterations !== want.iterations ||
            out_data.red_level !== want.red_level ||
            out_data.green_blue_level !== want.green_blue_level)
          note_mismatch("wrong word", want, out_data);
      end
    end
  end

  // Output side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL julia_escape_time_pixel");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ----------------------------------------------------------------- tests
  task automatic test_reset_view();
    in_word_t p;
    // corners, center and one top-row pixel of the default view; center stays at zero forever
    p = '{pixel_x: 10'd0,    pixel_y: 10'd0};    send_pixel(p);
    p = '{pixel_x: 10'd1023, pixel_y: 10'd1023}; send_pixel(p);
    p = '{pixel_x: 10'd1023, pixel_y: 10'd0};    send_pixel(p);
    p = '{pixel_x: 10'd0,    pixel_y: 10'd1023}; send_pixel(p);
    p = '{pixel_x: 10'd512,  pixel_y: 10'd512};  send_pixel(p);
    p = '{pixel_x: 10'd511,  pixel_y: 10'd0};    send_pixel(p);
  endtask

  task automatic test_escape_radius();
    in_word_t p;
    p = '{pixel_x: 10'd5, pixel_y: 10'd9};
    // |z0|^2 exactly 4 still iterates; one LSB beyond does not
    wait_drain();
    load_view(32'd0, 32'd0, 32'h2000_0000, 32'd0, 32'd0, 32'd0);
    send_pixel(p);
    wait_drain();
    load_view(32'd0, 32'd0, 32'he000_0000, 32'd0, 32'd0, 32'd0);
    send_pixel(p);
    wait_drain();
    load_view(32'd0, 32'd0, 32'd0, 32'h2000_0000, 32'd0, 32'd0);
    send_pixel(p);
    wait_drain();
    load_view(32'd0, 32'd0, 32'h2000_0001, 32'd0, 32'd0, 32'd0);
    send_pixel(p);
  endtask

  task automatic test_saturation();
    in_word_t p;
    // step writes carry bit 31, which the register drops
    wait_drain();
    load_view(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
              32'hffff_ffff, 32'hffff_ffff);
    p = '{pixel_x: 10'd0,    pixel_y: 10'd0};    send_pixel(p);
    p = '{pixel_x: 10'd1023, pixel_y: 10'd1023}; send_pixel(p);
    p = '{pixel_x: 10'd512,  pixel_y: 10'd512};  send_pixel(p);
    // z update overflows on the first iteration
    wait_drain();
    load_view(32'h7fff_ffff, 32'h8000_0000, 32'h2000_0000, 32'd0, 32'd0, 32'd0);
    p = '{pixel_x: 10'd3, pixel_y: 10'd3}; send_pixel(p);
  endtask

  task automatic test_spare_index();
    wait_drain();
    load_view(q428(-0.8), q428(0.156), 32'd0, 32'd0, STEP_RE_RST, STEP_IM_RST);
    // writes beyond the last register must leave the view alone
    write_reg(REG_SPARE_6, $urandom);
    write_reg(REG_SPARE_7, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_pixel(rand_pixel());
    send_pixel(rand_pixel());
  endtask

  task automatic test_random_views();
    int n;
    for (int view = 0; view < 8; view++) begin
      wait_drain();
      idle_on = (view != 1);
      case (view)
        0: load_view(q428(-0.8), q428(0.156), 32'd0, 32'd0, STEP_RE_RST, STEP_IM_RST);
        1: load_view(q428(0.285), q428(0.01), 32'd0, 32'd0, STEP_RE_RST, STEP_IM_RST);
        2: load_view(q428(-0.4), q428(0.6), rand_around(1 << 27), rand_around(1 << 27),
                     $urandom_range(0, 1 << 21), $urandom_range(0, 1 << 21));
        3: load_view(rand_around(1 << 29), rand_around(1 << 29), rand_around(1 << 29),
                     rand_around(1 << 29), $urandom_range(0, 1 << 20),
                     $urandom_range(0, 1 << 20));
        4: load_view(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 32'h7fff_ffff);
        5: load_view(rand_around(1 << 28), rand_around(1 << 28), rand_around(402653184),
                     rand_around(402653184), 32'd0, 32'd0);
        6: load_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: load_view(32'd0, 32'd0, 32'd0, 32'd0, STEP_RE_RST, STEP_IM_RST);
      endcase
      n = (view == 4 || view == 7) ? 30 : 65;
      repeat (n) send_pixel(rand_pixel());
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    wait_drain();
    load_view(q428(-0.7), q428(0.27), rand_around(1 << 26), rand_around(1 << 26),
              $urandom_range(1 << 19, 1 << 20), $urandom_range(1 << 19, 1 << 20));
    // hold the output while pixels keep coming so the input backs up
    hold_requests++;
    repeat (12) send_pixel(rand_pixel());
    // pause until every word is back, then resume
    wait_drain();
    repeat (12) send_pixel(rand_pixel());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_view();
    test_escape_radius();
    test_saturation();
    test_spare_index();
    test_random_views();
    test_backpressure();
    wait_drain();
    repeat (2 * DEF_MAX_ITERATIONS + 10) @(posedge clk);
    $display("Ran %0d pixels through %0d register settings, %0d words checked",
             pixels_sent, views_loaded, results_checked);
    $display("%0d pixels hit the iteration limit, %0d escaped at once, %0d mismatches",
             limit_hits, instant_escapes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS julia_escape_time_pixel");
    end else begin
      $display("FAIL julia_escape_time_pixel");
    end
    $finish;
  end

endmodule
